/* sv/fme_pkg.sv */
// Shared types, codes and constants for the fuzzy membership evaluator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fme_pkg;

  // Default full-scale degree
  localparam int unsigned FULL_DEGREE_DEF = 255;

  // Field and datapath widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned EDGE_W    = 16;
  localparam int unsigned SHAPE_W   = 3;
  localparam int unsigned DEG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned WIDE_W    = 18;  // signed edge-to-edge differences
  localparam int unsigned MAG_W     = 17;  // magnitude of such a difference
  localparam int unsigned DEG_MAX   = 255; // largest value of the degree field

  // Division by three: exact for spans below 2^THIRD_SHIFT
  localparam int unsigned  THIRD_SHIFT = 17;
  localparam logic [15:0]  THIRD_RECIP = 16'd43691;

  // Term shapes
  localparam logic [SHAPE_W-1:0] SHAPE_TRIANGLE  = 3'd0;
  localparam logic [SHAPE_W-1:0] SHAPE_BELL      = 3'd1;
  localparam logic [SHAPE_W-1:0] SHAPE_TRAPEZOID = 3'd2;
  localparam logic [SHAPE_W-1:0] SHAPE_S_RAMP    = 3'd3;
  localparam logic [SHAPE_W-1:0] SHAPE_Z_RAMP    = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TERM_SHAPE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_EDGE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_EDGE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_POINT = 2'd3;

  // How the final degree is formed from the quotient
  typedef enum logic [1:0] {
    KIND_ZERO,  // degree 0
    KIND_FULL,  // full degree
    KIND_RAMP,  // quotient, capped at full degree
    KIND_BELL   // full degree minus quotient, floored at zero
  } kind_t;

  // Configuration as seen by the datapath, edges sign-extended
  typedef struct packed {
    logic [SHAPE_W-1:0]       shape;
    logic signed [WIDE_W-1:0] lo;
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] pk;
    logic signed [WIDE_W-1:0] mid;
    logic signed [WIDE_W-1:0] half;
    logic signed [WIDE_W-1:0] third;
  } cfg_t;

endpackage

`default_nettype wire

/* sv/fme_cfg.sv */
// Configuration registers and the values derived from them (bell centre,
// bell half width, trapezoid third). Depends on fme_pkg.
`default_nettype none

module fme_cfg (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             cfg_we,
  input  wire  [fme_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [fme_pkg::EDGE_W-1:0]      cfg_wdata,
  output fme_pkg::cfg_t                   cfg_o
);
  import fme_pkg::*;

  logic [SHAPE_W-1:0]       shape_r;
  logic signed [EDGE_W-1:0] lo_r;
  logic signed [EDGE_W-1:0] hi_r;
  logic signed [EDGE_W-1:0] pk_r;
  logic signed [WIDE_W-1:0] mid_r, mid_nxt;
  logic signed [WIDE_W-1:0] half_r, half_nxt;
  logic signed [WIDE_W-1:0] third_r, third_nxt;

  logic signed [WIDE_W-1:0] lo_x, hi_x, pk_x, sum, sum_adj, span;
  logic [MAG_W-1:0]         span_pos;
  logic [MAG_W+15:0]        third_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shape_r <= '0;
      lo_r    <= '0;
      hi_r    <= '0;
      pk_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TERM_SHAPE: shape_r <= cfg_wdata[SHAPE_W-1:0];
        REG_LOWER_EDGE: lo_r    <= cfg_wdata;
        REG_UPPER_EDGE: hi_r    <= cfg_wdata;
        REG_PEAK_POINT: pk_r    <= cfg_wdata;
      endcase
    end
  end

  assign lo_x = WIDE_W'(lo_r);
  assign hi_x = WIDE_W'(hi_r);
  assign pk_x = WIDE_W'(pk_r);

  // Centre rounds toward zero
  assign sum     = lo_x + hi_x;
  assign sum_adj = sum + $signed({{(WIDE_W-1){1'b0}}, sum[WIDE_W-1]});
  assign mid_nxt = sum_adj >>> 1;
  assign half_nxt = hi_x - mid_nxt;

  // Third of a non-negative span by reciprocal multiply
  assign span       = hi_x - lo_x;
  assign span_pos   = span[WIDE_W-1] ? '0 : span[MAG_W-1:0];
  assign third_prod = (MAG_W+16)'(span_pos) * (MAG_W+16)'(THIRD_RECIP);
  assign third_nxt  = $signed({2'b00, third_prod[MAG_W+15:THIRD_SHIFT]});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r   <= '0;
      half_r  <= '0;
      third_r <= '0;
    end else begin
      mid_r   <= mid_nxt;
      half_r  <= half_nxt;
      third_r <= third_nxt;
    end
  end

  assign cfg_o.shape = shape_r;
  assign cfg_o.lo    = lo_x;
  assign cfg_o.hi    = hi_x;
  assign cfg_o.pk    = pk_x;
  assign cfg_o.mid   = mid_r;
  assign cfg_o.half  = half_r;
  assign cfg_o.third = third_r;

endmodule

`default_nettype wire

/* sv/fme_front.sv */
// Front of the pipeline: sample capture, shape decode into a numerator and
// denominator, and the two multiply stages. Depends on fme_pkg.
`default_nettype none

module fme_front #(
  parameter int unsigned FULL_DEGREE = fme_pkg::FULL_DEGREE_DEF
) (
  input  wire                                      clk,
  input  wire                                      en,
  input  wire signed [fme_pkg::SAMPLE_W-1:0]       in_sample,
  input  fme_pkg::cfg_t                            cfg_i,
  output logic [2*fme_pkg::MAG_W+$clog2(FULL_DEGREE+1)-1:0] n_o,
  output logic [2*fme_pkg::MAG_W-1:0]              d_o,
  output fme_pkg::kind_t                           kind_o
);
  import fme_pkg::*;

  localparam int unsigned FW = $clog2(FULL_DEGREE + 1);
  localparam int unsigned DW = 2 * MAG_W;
  localparam int unsigned NW = DW + FW;
  localparam logic [FW-1:0] F_VEC = FW'(FULL_DEGREE);

  logic signed [SAMPLE_W-1:0] x_r;

  logic signed [WIDE_W-1:0] x, lo, hi, pk, dm, num, den, lo_d, hi_d;
  logic [MAG_W-1:0]         dm_mag;
  logic                     in_support, use_ramp;
  kind_t                    kind_nxt;
  logic [MAG_W-1:0]         a_nxt, b_nxt, c_nxt, e_nxt;

  kind_t            kind_s1_r, kind_s2_r, kind_s3_r;
  logic [MAG_W-1:0] a_r, b_r, c_r, e_r;
  logic [DW-1:0]    n0_r, dd_r, d_r;
  logic [NW-1:0]    n_r;

  always_ff @(posedge clk) begin
    if (en) x_r <= in_sample;
  end

  assign x    = WIDE_W'(x_r);
  assign lo   = cfg_i.lo;
  assign hi   = cfg_i.hi;
  assign pk   = cfg_i.pk;
  assign dm   = x - cfg_i.mid;
  assign dm_mag = dm[WIDE_W-1] ? MAG_W'(-dm) : dm[MAG_W-1:0];
  assign lo_d = lo + cfg_i.third;
  assign hi_d = hi - cfg_i.third;
  assign in_support = (x >= lo) && (x <= hi);

  always_comb begin
    kind_nxt = KIND_ZERO;
    use_ramp = 1'b0;
    num      = '0;
    den      = '0;
    a_nxt    = '0;
    b_nxt    = '0;
    c_nxt    = MAG_W'(1);
    e_nxt    = MAG_W'(1);
    unique case (cfg_i.shape)
      SHAPE_TRIANGLE: begin
        if (in_support) begin
          use_ramp = 1'b1;
          if (x < pk) begin
            num = x - lo;
            den = pk - lo;
          end else begin
            num = hi - x;
            den = hi - pk;
          end
        end
      end
      SHAPE_BELL: begin
        if (in_support) begin
          if (cfg_i.half == '0) begin
            kind_nxt = KIND_FULL;
          end else begin
            kind_nxt = KIND_BELL;
            a_nxt    = dm_mag;
            b_nxt    = dm_mag;
            c_nxt    = cfg_i.half[MAG_W-1:0];
            e_nxt    = cfg_i.half[MAG_W-1:0];
          end
        end
      end
      SHAPE_TRAPEZOID: begin
        if (in_support) begin
          priority if (x > lo_d && x < hi_d) begin
            kind_nxt = KIND_FULL;
          end else if (x <= lo_d) begin
            use_ramp = 1'b1;
            num      = x - lo;
            den      = cfg_i.third;
          end else begin
            use_ramp = 1'b1;
            num      = hi - x;
            den      = cfg_i.third;
          end
        end
      end
      SHAPE_S_RAMP: begin
        priority if (x < lo) begin
          kind_nxt = KIND_ZERO;
        end else if (x > hi) begin
          kind_nxt = KIND_FULL;
        end else begin
          use_ramp = 1'b1;
          num      = x - lo;
          den      = hi - lo;
        end
      end
      SHAPE_Z_RAMP: begin
        priority if (x > hi) begin
          kind_nxt = KIND_ZERO;
        end else if (x < lo) begin
          kind_nxt = KIND_FULL;
        end else begin
          use_ramp = 1'b1;
          num      = hi - x;
          den      = hi - lo;
        end
      end
      default: kind_nxt = KIND_ZERO;
    endcase
    // Ramp with empty span goes straight to full degree
    if (use_ramp) begin
      if (den == '0) begin
        kind_nxt = KIND_FULL;
      end else begin
        kind_nxt = KIND_RAMP;
        a_nxt    = num[MAG_W-1:0];
        b_nxt    = MAG_W'(1);
        c_nxt    = den[MAG_W-1:0];
        e_nxt    = MAG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind_s1_r <= kind_nxt;
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      c_r       <= c_nxt;
      e_r       <= e_nxt;
      kind_s2_r <= kind_s1_r;
      n0_r      <= DW'(a_r) * DW'(b_r);
      dd_r      <= DW'(c_r) * DW'(e_r);
      kind_s3_r <= kind_s2_r;
      n_r       <= NW'(n0_r) * NW'(F_VEC);
      d_r       <= dd_r;
    end
  end

  assign n_o    = n_r;
  assign d_o    = d_r;
  assign kind_o = kind_s3_r;

endmodule

`default_nettype wire

/* sv/fme_div_step.sv */
// One restoring division stage: resolves one quotient bit per clock while en is high.
// Depends on fme_pkg.
`default_nettype none

module fme_div_step #(
  parameter int unsigned NW = 42,
  parameter int unsigned DW = 34,
  parameter int unsigned QW = 10,
  parameter int unsigned SH = 0
) (
  input  wire                clk,
  input  wire                en,
  input  wire  [NW-1:0]      rem_i,
  input  wire  [DW-1:0]      den_i,
  input  wire  [QW-1:0]      q_i,
  input  fme_pkg::kind_t     kind_i,
  output logic [NW-1:0]      rem_o,
  output logic [DW-1:0]      den_o,
  output logic [QW-1:0]      q_o,
  output fme_pkg::kind_t     kind_o
);
  import fme_pkg::*;

  localparam int unsigned CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] rem_ext, trial, diff;
  logic          ge;

  assign rem_ext = CW'(rem_i);
  assign trial   = CW'(den_i) << SH;
  assign diff    = rem_ext - trial;
  assign ge      = rem_ext >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o  <= ge ? diff[NW-1:0] : rem_i;
      den_o  <= den_i;
      q_o    <= {q_i[QW-2:0], ge};
      kind_o <= kind_i;
    end
  end

endmodule

`default_nettype wire

/* sv/fme_div.sv */
// Pipelined divider: a chain of restoring stages, most significant quotient
// bit first. Depends on fme_pkg and fme_div_step.
`default_nettype none

module fme_div #(
  parameter int unsigned NW = 42,
  parameter int unsigned DW = 34,
  parameter int unsigned QW = 10
) (
  input  wire                clk,
  input  wire                en,
  input  wire  [NW-1:0]      n_i,
  input  wire  [DW-1:0]      d_i,
  input  fme_pkg::kind_t     kind_i,
  output logic [QW-1:0]      q_o,
  output fme_pkg::kind_t     kind_o
);
  import fme_pkg::*;

  logic [NW-1:0] rem_w  [QW+1];
  logic [DW-1:0] den_w  [QW+1];
  logic [QW-1:0] q_w    [QW+1];
  kind_t         kind_w [QW+1];

  assign rem_w[0]  = n_i;
  assign den_w[0]  = d_i;
  assign q_w[0]    = '0;
  assign kind_w[0] = kind_i;

  for (genvar k = 0; k < QW; k++) begin : g_step
    fme_div_step #(
      .NW (NW),
      .DW (DW),
      .QW (QW),
      .SH (QW - 1 - k)
    ) u_step (
      .clk    (clk),
      .en     (en),
      .rem_i  (rem_w[k]),
      .den_i  (den_w[k]),
      .q_i    (q_w[k]),
      .kind_i (kind_w[k]),
      .rem_o  (rem_w[k+1]),
      .den_o  (den_w[k+1]),
      .q_o    (q_w[k+1]),
      .kind_o (kind_w[k+1])
    );
  end

  assign q_o    = q_w[QW];
  assign kind_o = kind_w[QW];

endmodule

`default_nettype wire

/* sv/fuzzy_membership_evaluator.sv */
// Fuzzy membership evaluator, top level: pipeline valid bits, output register
// with skid stage. Depends on fme_pkg, fme_cfg, fme_front and fme_div.
//
// Takes one signed 16-bit sample per request and returns its membership
// degree (0..FULL_DEGREE, capped at 255) in the configured term: triangle,
// parabolic bell, trapezoid with a plateau over the middle third, S-ramp or
// Z-ramp; unknown shape codes give 0. The block sustains one request per
// clock while in_stall is low. The pipeline has one capture stage, one
// decode stage, two multiply stages, one stage per quotient bit in the
// divider (QW = clog2(4*FULL_DEGREE + 2) bits) and the output register.
// The divider resolves one quotient bit per stage, so its depth sets the
// latency. A skid register behind the output register lets the pipeline
// finish an in-flight request while the consumer stalls; in_stall rises
// only once that skid register is occupied. Write the configuration only
// while no request is in flight; derived values are registered from the
// edge registers and settle after them.
`default_nettype none

module fuzzy_membership_evaluator #(
  parameter int unsigned FULL_DEGREE = fme_pkg::FULL_DEGREE_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Configuration
  input  wire                                  cfg_we,
  input  wire  [fme_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [fme_pkg::EDGE_W-1:0]           cfg_wdata,
  // Sample requests
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  signed [fme_pkg::SAMPLE_W-1:0]  in_sample,
  // Degree results
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [fme_pkg::DEG_W-1:0]            out_degree
);
  import fme_pkg::*;

  localparam int unsigned FW    = $clog2(FULL_DEGREE + 1);
  localparam int unsigned QW    = $clog2(4 * FULL_DEGREE + 2);
  localparam int unsigned DW    = 2 * MAG_W;
  localparam int unsigned NW    = DW + FW;
  localparam int unsigned NPIPE = QW + 4;
  localparam int unsigned VW    = QW + 8;
  localparam int unsigned DEG_CAP = (FULL_DEGREE > DEG_MAX) ? DEG_MAX : FULL_DEGREE;

  cfg_t          cfg;
  logic          en;
  logic [NW-1:0] n_w;
  logic [DW-1:0] d_w;
  kind_t         kind_front, kind_div;
  logic [QW-1:0] q_w;

  logic [NPIPE-1:0] v_r;
  logic [VW-1:0]    q_ext, f_ext, val;
  logic [DEG_W-1:0] deg_c;

  logic             out_v_r, out_v_nxt;
  logic [DEG_W-1:0] out_deg_r, out_deg_nxt;
  logic             skid_v_r, skid_v_nxt;
  logic [DEG_W-1:0] skid_deg_r, skid_deg_nxt;

  // Whole pipeline advances while the skid register is free
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  fme_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  fme_front #(
    .FULL_DEGREE (FULL_DEGREE)
  ) u_front (
    .clk       (clk),
    .en        (en),
    .in_sample (in_sample),
    .cfg_i     (cfg),
    .n_o       (n_w),
    .d_o       (d_w),
    .kind_o    (kind_front)
  );

  fme_div #(
    .NW (NW),
    .DW (DW),
    .QW (QW)
  ) u_div (
    .clk    (clk),
    .en     (en),
    .n_i    (n_w),
    .d_i    (d_w),
    .kind_i (kind_front),
    .q_o    (q_w),
    .kind_o (kind_div)
  );

  // Valid bits travel alongside the payload stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NPIPE-2:0], in_valid};
    end
  end

  // Form the degree: cap ramps at full scale, floor the bell at zero
  assign q_ext = VW'(q_w);
  assign f_ext = VW'(FULL_DEGREE);

  always_comb begin
    unique case (kind_div)
      KIND_ZERO: val = '0;
      KIND_FULL: val = f_ext;
      KIND_RAMP: val = (q_ext > f_ext) ? f_ext : q_ext;
      KIND_BELL: val = (q_ext > f_ext) ? '0 : f_ext - q_ext;
      default:   val = '0;
    endcase
  end

  assign deg_c = (val > VW'(DEG_MAX)) ? DEG_W'(DEG_MAX) : val[DEG_W-1:0];

  // Output register and skid stage
  always_comb begin
    out_v_nxt    = out_v_r;
    out_deg_nxt  = out_deg_r;
    skid_v_nxt   = skid_v_r;
    skid_deg_nxt = skid_deg_r;
    if (skid_v_r) begin
      // Drain the skid register once the consumer takes the held result
      if (!out_stall) begin
        out_deg_nxt = skid_deg_r;
        skid_v_nxt  = 1'b0;
      end
    end else begin
      if (v_r[NPIPE-1]) begin
        if (!out_v_r || !out_stall) begin
          out_v_nxt   = 1'b1;
          out_deg_nxt = deg_c;
        end else begin
          skid_v_nxt   = 1'b1;
          skid_deg_nxt = deg_c;
        end
      end else if (out_v_r && !out_stall) begin
        out_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_deg_r  <= out_deg_nxt;
    skid_deg_r <= skid_deg_nxt;
  end

  assign out_valid  = out_v_r;
  assign out_degree = out_deg_r;

`ifndef SYNTHESIS
  // A result held in the skid register always sits behind a shown result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds a result while the output is empty");

  // A shown degree never exceeds the scale
  a_degree_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_degree) <= DEG_CAP))
    else $error("degree above full scale");

  // Taken result with nothing behind it leaves the output empty
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !skid_v_r && !v_r[NPIPE-1]) |=> !out_valid)
    else $error("result repeated after it was taken");
`endif

endmodule

`default_nettype wire

/* bench/tb_fuzzy_membership_evaluator.sv */
// Self-checking bench for the fuzzy membership evaluator: directed table, then random samples.
// Depends on fme_pkg and fuzzy_membership_evaluator; checks each degree against a local predictor.
`timescale 1ns / 1ps

module tb_fuzzy_membership_evaluator;
  import fme_pkg::*;

  localparam int FULL = FULL_DEGREE_DEF;
  localparam int LATENCY = 15;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TERM_SHAPE;
  logic [EDGE_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DEG_W-1:0] out_degree;

  fuzzy_membership_evaluator dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_sample(in_sample),
    .out_valid(out_valid), .out_stall(out_stall), .out_degree(out_degree)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor's copy of the term registers
  logic [SHAPE_W-1:0] term_shape;
  longint lo_edge, hi_edge, pk_point;

  logic [DEG_W-1:0] degree_queue[$];
  int errors = 0;
  bit quiet_rx = 0;     // long stretch with no idling on the receiver
  bit hold_off = 0;     // receiver holds off to fill the pipeline
  bit quiet_tx = 0;

  // Truncating scaled ratio; a zero divisor gives full degree
  function automatic longint scaled(longint num, longint den);
    if (den == 0) return FULL;
    return num * FULL / den;
  endfunction

  function automatic logic [DEG_W-1:0] membership(longint x);
    longint mu, m, w, d, t;
    case (term_shape)
      SHAPE_TRIANGLE: begin
        if (x > hi_edge || x < lo_edge) mu = 0;
        else if (x < pk_point) mu = scaled(x - lo_edge, pk_point - lo_edge);
        else mu = scaled(hi_edge - x, hi_edge - pk_point);
      end
      SHAPE_BELL: begin
        m = (lo_edge + hi_edge) / 2;
        w = hi_edge - m;
        d = x - m;
        if (x > hi_edge || x < lo_edge) mu = 0;
        else if (w == 0) mu = FULL;
        else mu = FULL - ((d * d * FULL) / w) / w;
      end
      SHAPE_TRAPEZOID: begin
        t = (hi_edge - lo_edge) / 3;
        if (x > hi_edge || x < lo_edge) mu = 0;
        else if (x > lo_edge + t && x < hi_edge - t) mu = FULL;
        else if (x <= lo_edge + t) mu = scaled(x - lo_edge, t);
        else mu = scaled(hi_edge - x, t);
      end
      SHAPE_S_RAMP: begin
        if (x < lo_edge) mu = 0;
        else if (x > hi_edge) mu = FULL;
        else mu = scaled(x - lo_edge, hi_edge - lo_edge);
      end
      SHAPE_Z_RAMP: begin
        if (x > hi_edge) mu = 0;
        else if (x < lo_edge) mu = FULL;
        else mu = scaled(hi_edge - x, hi_edge - lo_edge);
      end
      default: mu = 0;
    endcase
    if (mu < 0) mu = 0;
    if (mu > FULL) mu = FULL;
    if (mu > 255) mu = 255;
    return mu[DEG_W-1:0];
  endfunction

  // Write one register while idle and mirror it in the predictor
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [EDGE_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_TERM_SHAPE: term_shape = val[SHAPE_W-1:0];
      REG_LOWER_EDGE: lo_edge = longint'($signed(val));
      REG_UPPER_EDGE: hi_edge = longint'($signed(val));
      default:        pk_point = longint'($signed(val));
    endcase
  endtask

  task automatic set_term(logic [SHAPE_W-1:0] s, int lo, int hi, int pk);
    write_reg(REG_TERM_SHAPE, EDGE_W'(s));
    write_reg(REG_LOWER_EDGE, EDGE_W'(lo));
    write_reg(REG_UPPER_EDGE, EDGE_W'(hi));
    write_reg(REG_PEAK_POINT, EDGE_W'(pk));
    @(negedge clk);
  endtask

  // Offer one request, idling at random, and advance once it is taken
  task automatic send_sample(logic signed [SAMPLE_W-1:0] x);
    while (!quiet_tx && $urandom_range(99) < 36) @(negedge clk);
    in_valid = 1'b1;
    in_sample = x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    degree_queue.push_back(membership(longint'(x)));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain;
    while (degree_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  // Random edge near a boundary, near zero or anywhere
  function automatic int pick_edge();
    case ($urandom_range(3))
      0: return -32768 + $urandom_range(20);
      1: return 32767 - $urandom_range(20);
      2: return $signed(16'($urandom_range(400))) - 200;
      default: return $signed(16'($urandom));
    endcase
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int a, b;
    a = int'(lo_edge); b = int'(hi_edge);
    if (a > b) begin a = int'(hi_edge); b = int'(lo_edge); end
    if ($urandom_range(9) < 7) return SAMPLE_W'($urandom_range(b - a + 4) + a - 2);
    return SAMPLE_W'($urandom);
  endfunction

  // Directed table: shape, edges, sample, typed expectation or -1 for the predictor
  typedef struct {
    logic [SHAPE_W-1:0] shape;
    int lo, hi, pk, x, want;
  } row_t;

  row_t rows[] = '{
    '{SHAPE_TRIANGLE, 0, 0, 0, 0, 255},          // state after reset, zero divisor
    '{SHAPE_TRIANGLE, 0, 0, 0, 1, 0},
    '{SHAPE_TRIANGLE, -32768, 32767, 0, -32768, 0},
    '{SHAPE_TRIANGLE, -32768, 32767, 0, 32767, 0},
    '{SHAPE_TRIANGLE, -32768, 32767, 0, 0, 255},
    '{SHAPE_TRIANGLE, -100, 100, 300, 50, -1},   // misplaced peak
    '{SHAPE_BELL, -100, 100, 0, 0, 255},
    '{SHAPE_BELL, -101, 100, 0, -101, -1},       // bell floor near lo
    '{SHAPE_BELL, -32768, 32767, 0, -32768, -1},
    '{SHAPE_BELL, 5, 5, 0, 5, 255},
    '{SHAPE_TRAPEZOID, -300, 300, 0, 0, 255},
    '{SHAPE_TRAPEZOID, -300, 300, 0, -300, 0},
    '{SHAPE_TRAPEZOID, -300, 300, 0, -100, 255},
    '{SHAPE_TRAPEZOID, 0, 2, 0, 1, -1},          // zero third
    '{SHAPE_S_RAMP, -10, 10, 0, -32768, 0},
    '{SHAPE_S_RAMP, -10, 10, 0, 32767, 255},
    '{SHAPE_S_RAMP, -10, 10, 0, 3, -1},
    '{SHAPE_Z_RAMP, -10, 10, 0, -32768, 255},
    '{SHAPE_Z_RAMP, -10, 10, 0, 32767, 0},
    '{SHAPE_Z_RAMP, 20, -20, 0, 0, -1},          // reversed edges
    '{SHAPE_TRIANGLE, 20, -20, 0, 0, 0},
    '{3'd5, -10, 10, 0, 0, 0},                   // unknown shapes
    '{3'd7, -10, 10, 0, 0, 0}
  };

  // Receiver: random idling, a quiet stretch and a long hold-off
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (quiet_rx) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 36);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (degree_queue.size() == 0) begin
        $display("%0t: unexpected degree %0d", $time, out_degree);
        errors++;
      end else begin
        if (out_degree !== degree_queue[0]) begin
          $display("%0t: degree mismatch, expected %0d actual %0d",
                   $time, degree_queue[0], out_degree);
          errors++;
        end
        void'(degree_queue.pop_front());
      end
    end
  end

  initial begin
    term_shape = SHAPE_TRIANGLE; lo_edge = 0; hi_edge = 0; pk_point = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed rows; the first runs on reset values
    foreach (rows[i]) begin
      if (i > 0) begin
        drain();
        set_term(rows[i].shape, rows[i].lo, rows[i].hi, rows[i].pk);
      end
      send_sample(SAMPLE_W'(rows[i].x));
      if (rows[i].want >= 0 && degree_queue[$] !== DEG_W'(rows[i].want)) begin
        $display("%0t: table row %0d, expected %0d actual %0d",
                 $time, i, rows[i].want, degree_queue[$]);
        errors++;
      end
    end

    // Random phases of a term each
    for (int ph = 0; ph < 30; ph++) begin
      int lo, hi, pk, t;
      drain();
      lo = pick_edge(); hi = pick_edge();
      if ($urandom_range(9) < 8 && lo > hi) begin t = lo; lo = hi; hi = t; end
      pk = ($urandom_range(3) == 0) ? pick_edge() : lo + (hi - lo) / 2 + $urandom_range(4) - 2;
      set_term(3'($urandom_range(7)), lo, hi, pk);
      quiet_rx = (ph == 10);
      quiet_tx = (ph == 10);
      if (ph == 5) begin
        fork
          begin
            hold_off = 1;
            repeat (60) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      // Offer more than the pipeline holds while the receiver holds off
      repeat ((ph == 5) ? 30 : 14) send_sample(pick_sample());
    end
    quiet_rx = 0;
    quiet_tx = 0;
    drain();
    if (errors == 0 && degree_queue.size() == 0) $display("fuzzy_membership_evaluator test passed");
    else $display("fuzzy_membership_evaluator test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("fuzzy_membership_evaluator test failed");
    $finish;
  end

endmodule

/* filelist.f */
sv/fme_pkg.sv
sv/fme_cfg.sv
sv/fme_front.sv
sv/fme_div_step.sv
sv/fme_div.sv
sv/fuzzy_membership_evaluator.sv
bench/tb_fuzzy_membership_evaluator.sv
